// File: rtl/ida_pkg.sv
// Shared constants and sizing helpers for the integer to decimal ASCII converter.
package ida_pkg;

   // Width of the value field on the input channel.
   localparam int VALUE_BITS = 64;

   // Default number of value bits that take part in the conversion.
   localparam int VALUE_WIDTH_DEFAULT = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Decimal digits needed for the largest unsigned number of the given width.
   // The scale factor approximates log10(2) closely enough for widths up to 64.
   function automatic int num_digits(input int width);
      return (width * 30103) / 100000 + 1;
   endfunction

endpackage

// File: rtl/integer_to_decimal_ascii_top.sv
// Top level of the integer to decimal ASCII converter with its sequencer.
//
// Usage: the request channel (req_valid, req_stall, req_cmd, req_value) takes one
// number per transfer. req_cmd = 0 reads the low VALUE_WIDTH bits of req_value as
// unsigned, req_cmd = 1 as two's complement. The response channel (rsp_valid,
// rsp_stall, rsp_out_char, rsp_last) returns the decimal text one character per
// transfer, most significant first, a leading '-' for negative numbers, and
// rsp_last set on the final character. Zero gives the single character '0'.
// Conversion runs one bit per cycle through a shared shift-and-add-3 unit; the
// sequencer then loads the characters into the output register one at a time.
// req_stall is high while the block is converting or emitting an item, so no new
// request is taken until its final character is loaded. A stalled response is
// held in the output register and the sequencer waits. The next request may be
// accepted while the final character still waits. Reset is synchronous and
// returns the block to idle with no response pending.
module integer_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [ida_pkg::VALUE_BITS-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_char,
   output logic                           rsp_last
);

   localparam int NumDigits = ida_pkg::num_digits(VALUE_WIDTH);
   localparam int BcdW      = 4 * NumDigits;
   localparam int LenW      = $clog2(NumDigits + 1);
   localparam int IdxW      = $clog2(NumDigits);
   localparam int CntW      = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BcdW-1:0]        bcd_ff, bcd_in;
   logic [LenW-1:0]        len_ff, len_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [IdxW-1:0]        idx_ff, idx_in;
   logic                   sign_ff, sign_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] value_w;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic [VALUE_WIDTH-1:0] bin_step;
   logic [BcdW-1:0]        bcd_step;
   logic [3:0]             new_nib;
   logic [3:0]             emit_nib;
   logic [LenW-1:0]        len_step;
   logic                   out_load;

   assign value_w = req_value[VALUE_WIDTH-1:0];
   assign neg     = req_cmd & value_w[VALUE_WIDTH-1];
   assign mag     = neg ? (~value_w + VALUE_WIDTH'(1)) : value_w;

   ida_dabble_step #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NumDigits)
   ) u_step (
      .bin_i (bin_ff),
      .bcd_i (bcd_ff),
      .bin_o (bin_step),
      .bcd_o (bcd_step)
   );

   // The digit count grows by at most one per step, so only the digit just
   // above the current count needs checking.
   always_comb begin
      new_nib  = 4'd0;
      emit_nib = 4'd0;
      for (int i = 0; i < NumDigits; i++) begin
         if (len_ff == LenW'(i)) begin
            new_nib = bcd_step[4*i +: 4];
         end
         if (idx_ff == IdxW'(i)) begin
            emit_nib = bcd_ff[4*i +: 4];
         end
      end
   end

   assign len_step = (len_ff < LenW'(NumDigits) && new_nib != 4'd0) ? len_ff + LenW'(1)
                                                                    : len_ff;
   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in   = mag;
               bcd_in   = '0;
               len_in   = LenW'(1);
               cnt_in   = CntW'(VALUE_WIDTH);
               sign_in  = neg;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bin_in = bin_step;
            bcd_in = bcd_step;
            len_in = len_step;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               idx_in   = IdxW'(len_step - LenW'(1));
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = ida_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = ida_pkg::CHAR_ZERO + {4'd0, emit_nib};
                  rsp_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - IdxW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      sign_ff     <= sign_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // A request transfer starts a fresh conversion with a cleared BCD register.
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CONV && bcd_ff == '0 && len_ff == LenW'(1))
      else $error("conversion did not start from a clean state");

   // The bit counter never runs out while converting.
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> cnt_ff != '0)
      else $error("bit counter empty during conversion");

   // The digit count stays within the BCD register.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> len_ff != '0 && len_ff <= LenW'(NumDigits))
      else $error("digit count out of range");

   // Loading the final character returns the sequencer to idle.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      out_load && rsp_last_in |=> state_ff == ST_IDLE)
      else $error("emitting after the final character");

   // A sign character is always followed by at least one digit.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_char_ff == ida_pkg::CHAR_MINUS |-> !rsp_last_ff)
      else $error("minus sign marked as final character");

endmodule

// File: rtl/ida_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion unit.
module ida_dabble_step #(
   parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEFAULT,
   parameter int NUM_DIGITS  = ida_pkg::num_digits(ida_pkg::VALUE_WIDTH_DEFAULT)
) (
   input  logic [VALUE_WIDTH-1:0]  bin_i,
   input  logic [4*NUM_DIGITS-1:0] bcd_i,
   output logic [VALUE_WIDTH-1:0]  bin_o,
   output logic [4*NUM_DIGITS-1:0] bcd_o
);

   logic [4*NUM_DIGITS-1:0] adj;

   // Every digit of five or more is corrected before the doubling shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_i[4*i +: 4] >= 4'd5) ? bcd_i[4*i +: 4] + 4'd3
                                                   : bcd_i[4*i +: 4];
      end
   end

   assign bcd_o = {adj[4*NUM_DIGITS-2:0], bin_i[VALUE_WIDTH-1]};
   assign bin_o = {bin_i[VALUE_WIDTH-2:0], 1'b0};

endmodule

// File: verif/decimal_text_checker.sv
// Checker that predicts the decimal text of each accepted number and compares every character.
`timescale 1ns / 1ps

module decimal_text_checker #(
   parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [ida_pkg::VALUE_BITS-1:0] req_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [7:0]                     rsp_out_char,
   input  logic                           rsp_last,
   output int                             failures,
   output int                             pending_chars
);

   localparam int MAX_CHARS = 20;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];
   int            fail_count;

   initial begin
      fail_count = 0;
   end

   // Appends the characters that one number must produce, most significant first.
   function automatic void queue_decimal_text(input logic cmd,
                                              input logic [ida_pkg::VALUE_BITS-1:0] value);
      logic [63:0]   mask;
      logic [63:0]   magnitude;
      logic          negative;
      logic [3:0]    digits [0:MAX_CHARS-1];
      int            num_digits;
      text_char_type item;
      mask = (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
      magnitude = 64'(value) & mask;
      negative = 1'b0;
      // The most negative value wraps back to itself here and is then read as unsigned.
      if (cmd && magnitude[VALUE_WIDTH-1]) begin
         negative = 1'b1;
         magnitude = (~magnitude + 64'd1) & mask;
      end
      num_digits = 0;
      do begin
         digits[num_digits] = 4'(magnitude % 64'd10);
         magnitude = magnitude / 64'd10;
         num_digits++;
      end while (magnitude != 64'd0 && num_digits < MAX_CHARS);
      if (negative && num_digits < MAX_CHARS) begin
         item.text_char = ida_pkg::CHAR_MINUS;
         item.last = 1'b0;
         expected_text.push_back(item);
      end
      for (int k = num_digits - 1; k >= 0; k--) begin
         item.text_char = ida_pkg::CHAR_ZERO + 8'(digits[k]);
         item.last = (k == 0);
         expected_text.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            queue_decimal_text(req_cmd, req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual char %h last %b",
                        $time, rsp_out_char, rsp_last);
               fail_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_out_char !== want.text_char || rsp_last !== want.last) begin
                  $display({"%0t: character mismatch: expected char %h last %b, ",
                            "actual char %h last %b"},
                           $time, want.text_char, want.last, rsp_out_char, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      failures <= fail_count;
      pending_chars <= expected_text.size();
   end

endmodule

// File: verif/tb_top.sv
// Testbench top: clock, reset, number stimulus, response stalls and the final verdict.
`timescale 1ns / 1ps

module tb_top;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_cmd;
   logic [ida_pkg::VALUE_BITS-1:0] req_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [7:0]                     rsp_out_char;
   logic                           rsp_last;
   int                             failures;
   int                             pending_chars;

   logic idle_on;
   logic hold_off_request;
   logic hold_off_done;

   integer_to_decimal_ascii_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   decimal_text_checker #(
      .VALUE_WIDTH (ida_pkg::VALUE_WIDTH_DEFAULT)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .failures      (failures),
      .pending_chars (pending_chars)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[integer_to_decimal_ascii_top] ERROR");
      $finish;
   end

   // Offers one number and returns at the falling edge after its transfer.
   task automatic send_number(input logic cmd, input logic [63:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_value = value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Picks a value from a mix that reaches short, long, boundary and negative texts.
   function automatic logic [63:0] random_value();
      logic [63:0] full;
      logic [63:0] power;
      full = {$urandom(), $urandom()};
      power = 64'd1;
      case ($urandom_range(0, 5))
         0: return full;
         1: return 64'($urandom_range(0, 999));
         2: return full >> $urandom_range(0, 63);
         3: begin
            repeat ($urandom_range(0, 19)) power = power * 64'd10;
            return power + 64'($urandom_range(0, 2)) - 64'd1;
         end
         4: return -64'($urandom_range(1, 1000));
         default: begin
            if ($urandom_range(0, 1) == 0)
               return {1'b1, 63'd0} + 64'($urandom_range(0, 3));
            return {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
         end
      endcase
   endfunction

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall = 1'b0;
            hold_off_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_value = '0;
      idle_on = 1'b1;
      hold_off_request = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_number(1'b0, 64'd0);
      send_number(1'b1, 64'd0);
      send_number(1'b0, 64'd1);
      send_number(1'b1, 64'd1);
      send_number(1'b0, 64'd9);
      send_number(1'b0, 64'd10);
      send_number(1'b0, 64'd99);
      send_number(1'b0, 64'd100);
      send_number(1'b0, {64{1'b1}});
      send_number(1'b1, {64{1'b1}});
      // Most negative signed value and the same pattern read unsigned.
      send_number(1'b1, {1'b1, 63'd0});
      send_number(1'b0, {1'b1, 63'd0});
      send_number(1'b1, {1'b0, {63{1'b1}}});
      send_number(1'b0, 64'd10000000000000000000);
      send_number(1'b0, 64'd9999999999999999999);
      send_number(1'b1, -64'd10);
      send_number(1'b1, 64'd123456789);
      send_number(1'b0, {32{2'b10}});
      send_number(1'b1, {32{2'b01}});
      send_number(1'b1, {32{2'b10}});

      for (int n = 0; n < 80; n++) begin
         // The receiver holds off while numbers keep coming, so the block backs up.
         if (n == 40) hold_off_request = 1'b1;
         send_number(1'($urandom_range(0, 1)), random_value());
      end

      idle_on = 1'b0;
      for (int n = 0; n < 20; n++) begin
         send_number(1'($urandom_range(0, 1)), random_value());
      end
      req_valid = 1'b0;

      while (pending_chars != 0 || (hold_off_request && !hold_off_done)) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("[integer_to_decimal_ascii_top] OK");
      end else begin
         $display("[integer_to_decimal_ascii_top] ERROR");
      end
      $finish;
   end

endmodule
